[hw/rtl/rhms_pkg.sv]
package rhms_pkg;

   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 512;
   localparam int RUN_LENGTH_DEF = 5;

   // 32768 * 900 * 16: the position denominator
   localparam logic [28:0] POS_DEN  = 29'd471859200;
   localparam logic [28:0] HALF_DEN = 29'd235929600;

   // signed sample coordinate width, holds center +/- 1024 pixels
   localparam int QW = 13;

   localparam logic [9:0] ELEV_TOP = 10'd900;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_RADIUS = 2'd2;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic signed [2:0] dq;
      logic [28:0]       dr;
   } split_type;

   localparam logic [15:0] SIN_TABLE [0:90] = '{
      16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
      16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
      16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
      16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
      16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
      16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
      16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
      16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
      16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
      16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
      16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
      16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
      16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32767
   };

   // angle in 0..359 -> Q1.15 sine
   function automatic logic signed [16:0] sin_deg(input logic [8:0] a);
      logic [15:0] mag;
      logic        neg;
      mag = 16'd0;
      neg = 1'b0;
      if (a <= 9'd90) begin
         mag = SIN_TABLE[7'(a)];
      end else if (a <= 9'd180) begin
         mag = SIN_TABLE[7'(9'd180 - a)];
      end else if (a <= 9'd270) begin
         mag = SIN_TABLE[7'(a - 9'd180)];
         neg = 1'b1;
      end else begin
         mag = SIN_TABLE[7'(9'd360 - a)];
         neg = 1'b1;
      end
      return neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
   endfunction

   // one conditional subtract of 360
   function automatic logic [8:0] wrap_deg(input logic [9:0] a);
      return (a >= 10'd360) ? 9'(a - 10'd360) : 9'(a);
   endfunction

   // floor split of a step delta by POS_DEN; |p| < 2 * POS_DEN
   function automatic split_type split_step(input logic signed [31:0] p);
      logic signed [32:0] pe;
      logic signed [32:0] d;
      logic signed [32:0] r;
      split_type          s;
      pe = 33'(p);
      d  = signed'({4'b0000, POS_DEN});
      if (pe >= d) begin
         s.dq = 3'sd1;
         r    = pe - d;
      end else if (pe >= 33'sd0) begin
         s.dq = 3'sd0;
         r    = pe;
      end else if (pe >= -d) begin
         s.dq = -3'sd1;
         r    = pe + d;
      end else begin
         s.dq = -3'sd2;
         r    = pe + d + d;
      end
      s.dr = r[28:0];
      return s;
   endfunction

endpackage

[hw/rtl/rhms_req_if.sv]
interface rhms_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [8:0] pixel_col;
   logic [8:0] pixel_row;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [8:0] azimuth;

   modport source (
      output valid, kind, pixel_col, pixel_row, red, green, blue, azimuth,
      input  ready
   );
   modport sink (
      input  valid, kind, pixel_col, pixel_row, red, green, blue, azimuth,
      output ready
   );
endinterface

[hw/rtl/rhms_rsp_if.sv]
interface rhms_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] azimuth_out;
   logic [9:0] mask_elevation;

   modport source (
      output valid, azimuth_out, mask_elevation,
      input  ready
   );
   modport sink (
      input  valid, azimuth_out, mask_elevation,
      output ready
   );
endinterface

[hw/rtl/radial_horizon_mask_scan.sv]
// Radial horizon mask scan.
// req_bus (valid/ready) takes two kinds of word. A load word writes one dark
// bit (dark = red, green and blue all below 255) into the on-chip pixel map.
// A query word walks the ray at the given azimuth from
// elevation 900 down to 0 tenths, one map sample per cycle, and returns one
// rsp_bus word with the azimuth echoed and the elevation where the dark run
// began (900 reported as 0).
// A query first passes setup states (sine product, cosine product, splits),
// then walks the elevation samples through the single map read port and
// its registered read, then hands the result off; a run of RUN_LENGTH dark
// samples ends the walk early. req_bus.ready is low for the whole walk. A
// query while a stored size is zero gives no word.
// The result sits in an output register: if rsp_bus stalls, loads are still
// taken; a second query finishes its walk and then waits for the register.
// csr_* writes width, height and radius; use them while idle.
// Reset (synchronous) clears control and sets the registers to 512, 512 and
// 4096; the map is undefined until each pixel read by a query is loaded.
module radial_horizon_mask_scan #(
   parameter int MAX_WIDTH  = rhms_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = rhms_pkg::MAX_HEIGHT_DEF,
   parameter int RUN_LENGTH = rhms_pkg::RUN_LENGTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rhms_req_if.sink    req_bus,
   rhms_rsp_if.source  rsp_bus,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int AW = CW + RW;
   localparam int QW = rhms_pkg::QW;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SIN   = 3'd1;
   localparam logic [2:0] S_COS   = 3'd2;
   localparam logic [2:0] S_SPLIT = 3'd3;
   localparam logic [2:0] S_WALK  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [9:0]  w_cfg_ff, w_cfg_in;
   logic [9:0]  h_cfg_ff, h_cfg_in;
   logic [13:0] rad_ff, rad_in;

   logic [2:0]  state_ff, state_in;
   logic [8:0]  az_ff, az_in;
   logic [8:0]  ang_ff, ang_in;
   logic [9:0]  w_ff, w_in;
   logic [9:0]  h_ff, h_in;
   logic signed [31:0] prod_ff, prod_in;
   rhms_pkg::split_type sx_ff, sx_in;
   rhms_pkg::split_type sy_ff, sy_in;
   logic signed [QW-1:0] qx_ff, qx_in;
   logic signed [QW-1:0] qy_ff, qy_in;
   logic [28:0] rx_ff, rx_in;
   logic [28:0] ry_ff, ry_in;
   logic [9:0]  e0_ff, e0_in;
   logic        iss_ff, iss_in;
   logic        v1_ff, v1_in;
   logic        inb1_ff, inb1_in;
   logic [9:0]  e1_ff, e1_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [9:0]  start_ff, start_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [8:0]  rsp_az_ff, rsp_az_in;
   logic [9:0]  rsp_el_ff, rsp_el_in;

   logic        mem [0:(2**AW)-1];
   logic        mem_q_ff;
   logic        mem_we;
   logic        mem_wd;
   logic [AW-1:0] waddr;
   logic [AW-1:0] raddr;

   logic        req_acc;
   logic [9:0]  w_clamp;
   logic [9:0]  h_clamp;
   logic [29:0] sum_x, sum_y;
   logic        wrap_x, wrap_y;
   logic        inb0;
   logic        stop;
   logic [2:0]  cnt_inc;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_acc = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.azimuth_out    = rsp_az_ff;
   assign rsp_bus.mask_elevation = rsp_el_ff;

   assign w_clamp = (int'(w_cfg_ff) > MAX_WIDTH)  ? 10'(MAX_WIDTH)  : w_cfg_ff;
   assign h_clamp = (int'(h_cfg_ff) > MAX_HEIGHT) ? 10'(MAX_HEIGHT) : h_cfg_ff;

   // map port
   assign mem_we = req_acc && (req_bus.kind == rhms_pkg::KIND_LOAD)
                   && (int'(req_bus.pixel_col) < MAX_WIDTH)
                   && (int'(req_bus.pixel_row) < MAX_HEIGHT);
   assign mem_wd = (req_bus.red != 8'hFF) && (req_bus.green != 8'hFF)
                   && (req_bus.blue != 8'hFF);
   assign waddr  = {RW'(req_bus.pixel_row), CW'(req_bus.pixel_col)};
   assign raddr  = {RW'($unsigned(qy_ff)), CW'($unsigned(qx_ff))};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= mem_wd;
      end
      mem_q_ff <= mem[raddr];
   end

   // position steppers: quotient/remainder of the sample coordinate
   assign sum_x  = {1'b0, rx_ff} + {1'b0, sx_ff.dr};
   assign sum_y  = {1'b0, ry_ff} + {1'b0, sy_ff.dr};
   assign wrap_x = (sum_x >= {1'b0, rhms_pkg::POS_DEN});
   assign wrap_y = (sum_y >= {1'b0, rhms_pkg::POS_DEN});

   assign inb0 = (qx_ff >= 0) && (qx_ff < signed'(QW'(w_ff)))
                 && (qy_ff >= 0) && (qy_ff < signed'(QW'(h_ff)));

   assign cnt_inc = cnt_ff + 3'd1;

   always_comb begin
      w_cfg_in     = w_cfg_ff;
      h_cfg_in     = h_cfg_ff;
      rad_in       = rad_ff;
      state_in     = state_ff;
      az_in        = az_ff;
      ang_in       = ang_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      prod_in      = prod_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      e0_in        = e0_ff;
      iss_in       = iss_ff;
      v1_in        = v1_ff;
      inb1_in      = inb1_ff;
      e1_in        = e1_ff;
      cnt_in       = cnt_ff;
      start_in     = start_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_az_in    = rsp_az_ff;
      rsp_el_in    = rsp_el_ff;
      stop         = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            rhms_pkg::CSR_WIDTH:  w_cfg_in = csr_wdata[9:0];
            rhms_pkg::CSR_HEIGHT: h_cfg_in = csr_wdata[9:0];
            rhms_pkg::CSR_RADIUS: rad_in   = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc && (req_bus.kind == rhms_pkg::KIND_QUERY)) begin
               az_in  = req_bus.azimuth;
               ang_in = rhms_pkg::wrap_deg({1'b0, req_bus.azimuth});
               w_in   = w_clamp;
               h_in   = h_clamp;
               if ((w_clamp != 10'd0) && (h_clamp != 10'd0)) begin
                  state_in = S_SIN;
               end
            end
         end
         S_SIN: begin
            prod_in  = 32'(rhms_pkg::sin_deg(ang_ff) * signed'({1'b0, rad_ff}));
            ang_in   = rhms_pkg::wrap_deg(10'(az_ff) + 10'd90);
            state_in = S_COS;
         end
         S_COS: begin
            prod_in  = 32'(rhms_pkg::sin_deg(ang_ff) * signed'({1'b0, rad_ff}));
            sx_in    = rhms_pkg::split_step(prod_ff);
            state_in = S_SPLIT;
         end
         S_SPLIT: begin
            sy_in    = rhms_pkg::split_step(prod_ff);
            // step 0 sits at (size + 1) / 2 exactly
            qx_in    = signed'(QW'(({1'b0, w_ff} + 11'd1) >> 1));
            qy_in    = signed'(QW'(({1'b0, h_ff} + 11'd1) >> 1));
            rx_in    = w_ff[0] ? 29'd0 : rhms_pkg::HALF_DEN;
            ry_in    = h_ff[0] ? 29'd0 : rhms_pkg::HALF_DEN;
            e0_in    = rhms_pkg::ELEV_TOP;
            iss_in   = 1'b1;
            v1_in    = 1'b0;
            cnt_in   = 3'd0;
            start_in = 10'd0;
            state_in = S_WALK;
         end
         S_WALK: begin
            // issue stage: read map at current sample, advance position
            v1_in = iss_ff;
            if (iss_ff) begin
               inb1_in = inb0;
               e1_in   = e0_ff;
               rx_in   = wrap_x ? 29'(sum_x - {1'b0, rhms_pkg::POS_DEN}) : sum_x[28:0];
               ry_in   = wrap_y ? 29'(sum_y - {1'b0, rhms_pkg::POS_DEN}) : sum_y[28:0];
               qx_in   = qx_ff + QW'(sx_ff.dq) + (wrap_x ? QW'(1) : QW'(0));
               qy_in   = qy_ff + QW'(sy_ff.dq) + (wrap_y ? QW'(1) : QW'(0));
               if (e0_ff == 10'd0) begin
                  iss_in = 1'b0;
               end else begin
                  e0_in = e0_ff - 10'd1;
               end
            end
            // run stage: map bit is back
            if (v1_ff) begin
               if (inb1_ff) begin
                  if (mem_q_ff) begin
                     cnt_in = cnt_inc;
                     if (cnt_ff == 3'd0) begin
                        start_in = e1_ff;
                     end
                     if (int'(cnt_inc) >= RUN_LENGTH) begin
                        stop = 1'b1;
                     end
                  end else begin
                     cnt_in = 3'd0;
                  end
               end
               if (e1_ff == 10'd0) begin
                  stop = 1'b1;
               end
            end
            if (stop) begin
               iss_in   = 1'b0;
               v1_in    = 1'b0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_az_in    = az_ff;
               rsp_el_in    = (start_ff == rhms_pkg::ELEV_TOP) ? 10'd0 : start_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_cfg_ff     <= 10'd512;
         h_cfg_ff     <= 10'd512;
         rad_ff       <= 14'd4096;
         state_ff     <= S_IDLE;
         iss_ff       <= 1'b0;
         v1_ff        <= 1'b0;
         cnt_ff       <= 3'd0;
         start_ff     <= 10'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         w_cfg_ff     <= w_cfg_in;
         h_cfg_ff     <= h_cfg_in;
         rad_ff       <= rad_in;
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         v1_ff        <= v1_in;
         cnt_ff       <= cnt_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      az_ff     <= az_in;
      ang_ff    <= ang_in;
      w_ff      <= w_in;
      h_ff      <= h_in;
      prod_ff   <= prod_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      qx_ff     <= qx_in;
      qy_ff     <= qy_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      e0_ff     <= e0_in;
      inb1_ff   <= inb1_in;
      e1_ff     <= e1_in;
      rsp_az_ff <= rsp_az_in;
      rsp_el_ff <= rsp_el_in;
   end

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) <= RUN_LENGTH)
      else $error("run count past run length");

   a_pipe_in_walk: assert property (@(posedge clock) disable iff (reset)
      (v1_ff || iss_ff) |-> (state_ff == S_WALK))
      else $error("walk pipeline active outside walk");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_bus.kind == rhms_pkg::KIND_QUERY)
       && (w_clamp != 10'd0) && (h_clamp != 10'd0)) |=> !req_bus.ready)
      else $error("ready during query walk");

   a_run_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && v1_ff && inb1_ff && mem_q_ff && cnt_ff == 3'd0)
      |=> (start_ff == $past(e1_ff)))
      else $error("run start not recorded");

endmodule
